// File: design/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg: shared types and constants for the crash lockout table
// Request/result layouts, register indexes, status codes and the hash step.
// ----------------------------------------------------------------------------
package clt_pkg;

	localparam int BUCKETS_DEF = 512;
	localparam int WAYS_DEF    = 4;

	localparam logic [31:0] RESET_EXPIRY     = 32'd120;
	localparam logic [31:0] RESET_SUSPENSION = 32'd600;
	localparam logic [7:0]  RESET_LIMIT      = 8'd5;

	localparam logic [47:0] TIME_MAX  = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam logic [1:0] REG_EXPIRY  = 2'd0;
	localparam logic [1:0] REG_SUSPEND = 2'd1;
	localparam logic [1:0] REG_LIMIT   = 2'd2;

	localparam logic [1:0] ST_ALLOWED = 2'd0;
	localparam logic [1:0] ST_DENIED  = 2'd1;
	localparam logic [1:0] ST_NOFILE  = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic KIND_CRASH = 1'b0;

	typedef struct packed {
		logic        kind;
		logic [31:0] owner_id;
		logic [63:0] file_id;
		logic [31:0] mount_id;
		logic        file_present;
		logic        guard_on;
		logic [47:0] now;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       entry_hit;
		logic [7:0] crash_count;
		logic       suspended_now;
	} rsp_t;

	// one FNV-1 byte step: multiply then xor
	function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
		logic [31:0] p;
		p = h * FNV_PRIME;
		return p ^ {24'd0, b};
	endfunction

	function automatic logic [47:0] add_sat(logic [47:0] t, logic [31:0] d);
		logic [48:0] s;
		s = {1'b0, t} + {17'd0, d};
		return s[48] ? TIME_MAX : s[47:0];
	endfunction

endpackage

// File: design/clt_front.sv
// ----------------------------------------------------------------------------
// clt_front: request intake and bucket hash
// Take a request, hash its 16 key bytes one byte a cycle, reduce the hash to a
// bucket via registered quotient and remainder steps, push it to the queue.
// ----------------------------------------------------------------------------
module clt_front #(
	parameter int BUCKETS = clt_pkg::BUCKETS_DEF,
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  clt_pkg::req_t   req,
	output logic            q_push,
	input  logic            q_full,
	output clt_pkg::req_t   q_req,
	output logic [BW-1:0]   q_bucket
);
	// bucket = hash mod BUCKETS by reciprocal: the estimated quotient is low
	// by at most one, so one compare and subtract finishes the remainder
	localparam int          LB    = $clog2(BUCKETS);
	localparam logic [32:0] RECIP = 33'((65'd1 << (32 + LB)) / BUCKETS);
	localparam logic [31:0] DIV   = 32'(BUCKETS);

	localparam logic [4:0] IDX_QUOT = 5'd16;
	localparam logic [4:0] IDX_REM  = 5'd17;
	localparam logic [4:0] IDX_DONE = 5'd18;

	logic          busy_q;
	logic [4:0]    idx_q;
	logic [31:0]   hash_q;
	logic [31:0]   qe_q;
	logic [31:0]   rem_q;
	clt_pkg::req_t req_q;
	logic [127:0]  key;
	logic [7:0]    kbyte;
	logic [31:0]   hash_nx;
	logic [63:0]   pmul;
	logic [64:0]   prod;
	logic [31:0]   qest;
	logic [31:0]   rem_nx;

	assign key     = {req_q.mount_id, req_q.file_id, req_q.owner_id};
	assign kbyte   = key[idx_q[3:0]*8 +: 8];
	assign hash_nx = clt_pkg::fnv_step(hash_q, kbyte);

	assign pmul   = {32'd0, hash_q} * {32'd0, RECIP[31:0]};
	assign prod   = {1'b0, pmul} + (RECIP[32] ? {1'b0, hash_q, 32'd0} : 65'd0);
	assign qest   = 32'(prod >> (32 + LB));
	assign rem_nx = hash_q - qe_q * DIV;

	assign req_ready = !busy_q;
	assign q_push    = busy_q && idx_q == IDX_DONE && !q_full;
	assign q_req     = req_q;
	assign q_bucket  = BW'((rem_q >= DIV) ? rem_q - DIV : rem_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (!busy_q) begin
			if (req_valid) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end else if (idx_q != IDX_DONE) begin
			idx_q <= idx_q + 5'd1;
		end else if (!q_full) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req_valid) begin
			req_q  <= req;
			hash_q <= clt_pkg::FNV_BASIS;
		end else if (busy_q && !idx_q[4]) begin
			hash_q <= hash_nx;
		end
		if (busy_q && idx_q == IDX_QUOT) qe_q <= qest;
		if (busy_q && idx_q == IDX_REM)  rem_q <= rem_nx;
	end
endmodule

// File: design/clt_queue.sv
// ----------------------------------------------------------------------------
// clt_queue: two-entry queue between hash front and table back
// Hold classified requests with their bucket until the back end takes them.
// ----------------------------------------------------------------------------
module clt_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         nonempty,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign full     = cnt_q[1];
	assign nonempty = cnt_q != 2'd0;
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end
endmodule

// File: design/clt_back.sv
// ----------------------------------------------------------------------------
// clt_back: bucket read-modify-write engine
// Scan the ways of a bucket, decide, write back and present the result.
// ----------------------------------------------------------------------------
module clt_back #(
	parameter int BUCKETS = clt_pkg::BUCKETS_DEF,
	parameter int WAYS    = clt_pkg::WAYS_DEF,
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
	localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1,
	localparam int SLOTS = BUCKETS * WAYS,
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_nonempty,
	input  clt_pkg::req_t q_req,
	input  logic [BW-1:0] q_bucket,
	output logic          q_pop,
	input  logic [31:0]   expiry_window,
	input  logic [31:0]   suspension_time,
	input  logic [7:0]    crash_limit,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output clt_pkg::rsp_t rsp
);
	localparam logic [SW-1:0] WAYS_W = SW'(WAYS);

	typedef struct packed {
		logic [31:0] owner;
		logic [63:0] file;
		logic [31:0] mount;
		logic [7:0]  count;
		logic [47:0] expiry;
		logic [47:0] susp;
	} slot_t;

	typedef enum logic [2:0] {S_IDLE, S_READ, S_CMP, S_DEC, S_OUT, S_CLR} state_t;

	slot_t         mem_q [SLOTS];
	logic          vld_q [SLOTS];
	slot_t         rd_q;
	logic          rvld_q;
	state_t        state_q;
	clt_pkg::req_t req_q;
	logic [BW-1:0] bkt_q;
	logic [WW:0]   way_q;
	logic          found_q, free_q;
	logic [WW-1:0] fway_q, eway_q;
	logic [SW:0]   clr_q;
	clt_pkg::rsp_t rsp_q;
	logic          rv_q;

	logic          match;
	logic [SW-1:0] base_addr, scan_addr, tgt_addr;
	logic          ran_out;
	logic [7:0]    inc;
	logic [47:0]   exp_new, sus_new;
	slot_t         wr;

	assign base_addr = SW'(bkt_q) * WAYS_W;
	assign scan_addr = base_addr + SW'(way_q[WW-1:0]);
	assign tgt_addr  = base_addr + SW'(found_q ? fway_q : eway_q);
	assign match = rvld_q && rd_q.owner == req_q.owner_id
		&& rd_q.file == req_q.file_id && rd_q.mount == req_q.mount_id;
	assign ran_out = rd_q.expiry < req_q.now && rd_q.susp <= req_q.now;
	assign inc     = (rd_q.count == 8'hFF) ? 8'hFF : rd_q.count + 8'd1;
	assign exp_new = clt_pkg::add_sat(req_q.now, expiry_window);
	assign sus_new = clt_pkg::add_sat(req_q.now, suspension_time);

	assign q_pop     = state_q == S_IDLE && q_nonempty && !rv_q;
	assign rsp_valid = rv_q;
	assign rsp       = rsp_q;

	always_comb begin
		wr        = rd_q;
		wr.owner  = req_q.owner_id;
		wr.file   = req_q.file_id;
		wr.mount  = req_q.mount_id;
		wr.count  = 8'd1;
		wr.expiry = exp_new;
		wr.susp   = '0;
		if (found_q && !ran_out) begin
			wr = rd_q;
			if (inc >= crash_limit) begin
				wr.count  = '0;
				wr.expiry = '0;
				wr.susp   = sus_new;
			end else begin
				wr.count = inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			rv_q    <= 1'b0;
		end else begin
			if (rv_q && rsp_ready) rv_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (SW+1)'(SLOTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_pop) begin
						if (!q_req.file_present || !q_req.guard_on) begin
							rsp_q <= '{q_req.file_present ? clt_pkg::ST_ALLOWED
								: clt_pkg::ST_NOFILE, 1'b0, 8'd0, 1'b0};
							rv_q  <= 1'b1;
						end else begin
							state_q <= S_READ;
						end
						way_q   <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
					end
				end
				S_READ: state_q <= S_CMP;
				S_CMP: begin
					if (!found_q && match) begin
						found_q <= 1'b1;
						fway_q  <= way_q[WW-1:0];
					end
					if (!rvld_q && !free_q) begin
						free_q <= 1'b1;
						eway_q <= way_q[WW-1:0];
					end
					if (way_q == (WW+1)'(WAYS - 1) || (!found_q && match)) begin
						state_q <= S_DEC;
						way_q   <= {1'b0, found_q || match ? (match && !found_q ?
							way_q[WW-1:0] : fway_q) : way_q[WW-1:0]};
					end else begin
						way_q   <= way_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_DEC: begin
					// rd_q holds the hit entry when found (last read was that way)
					state_q <= S_OUT;
					if (found_q) begin
						if (req_q.kind == clt_pkg::KIND_CRASH) begin
							rsp_q <= '{clt_pkg::ST_ALLOWED, 1'b1, wr.count,
								wr.susp > req_q.now};
						end else if (ran_out) begin
							rsp_q <= '{clt_pkg::ST_ALLOWED, 1'b1, 8'd0, 1'b0};
						end else begin
							rsp_q <= '{(rd_q.susp > req_q.now) ? clt_pkg::ST_DENIED
								: clt_pkg::ST_ALLOWED, 1'b1, rd_q.count,
								rd_q.susp > req_q.now};
						end
					end else if (req_q.kind == clt_pkg::KIND_CRASH) begin
						rsp_q <= free_q ? '{clt_pkg::ST_ALLOWED, 1'b0, 8'd1, 1'b0}
							: '{clt_pkg::ST_FULL, 1'b0, 8'd0, 1'b0};
					end else begin
						rsp_q <= '{clt_pkg::ST_ALLOWED, 1'b0, 8'd0, 1'b0};
					end
				end
				S_OUT: begin
					rv_q    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// table storage: read one way at a time, write back at decision
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_pop) begin
			req_q <= q_req;
			bkt_q <= q_bucket;
		end
		if (state_q == S_READ) begin
			rd_q   <= mem_q[scan_addr];
			rvld_q <= vld_q[scan_addr];
		end
		if (state_q == S_DEC && req_q.kind == clt_pkg::KIND_CRASH && (found_q || free_q))
			mem_q[tgt_addr] <= wr;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLR)
			vld_q[clr_q[SW-1:0]] <= 1'b0;
		else if (state_q == S_DEC) begin
			if (req_q.kind == clt_pkg::KIND_CRASH && (found_q || free_q))
				vld_q[tgt_addr] <= 1'b1;
			else if (found_q && ran_out)
				vld_q[tgt_addr] <= 1'b0;
		end
	end
endmodule

// File: design/crash_lockout_table_core.sv
// ----------------------------------------------------------------------------
// crash_lockout_table_core: keyed crash-count lockout table
// Counts crashes per (owner, file, mount) key and denies suspended keys.
// ----------------------------------------------------------------------------
// After reset the back end runs a clearing pass over the BUCKETS*WAYS valid
// marks (2048 at the defaults) and answers no request until it ends; the
// front keeps taking and hashing requests meanwhile and stalls its input
// once the queue and its own holding register are full. Register writes are
// taken throughout. The front takes a request, hashes the key bytes one
// FNV-1 step per cycle, reduces the hash to a bucket by reciprocal
// multiplication through a registered quotient estimate and remainder, and
// pushes it to the queue once the queue has room; it takes the next request
// only after the push. A two-entry queue carries requests to the back end,
// which reads the bucket one way at a time from a single-port table
// (stopping at the first match), writes the entry back on a crash report and
// raises the result. The back end takes the next request only once its
// result is taken; the front hashes the next request while the back end
// works on the previous one. Requests that have no program image or have
// the guard off skip the table and raise their result in the cycle after
// the back end takes them.
module crash_lockout_table_core #(
	parameter int BUCKETS = clt_pkg::BUCKETS_DEF,
	parameter int WAYS    = clt_pkg::WAYS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  clt_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output clt_pkg::rsp_t out_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int QW = $bits(clt_pkg::req_t) + BW;

	logic [31:0] expiry_q, suspend_q;
	logic [7:0]  limit_q;

	logic          push, full, pop, nonempty;
	clt_pkg::req_t f_req, b_req;
	logic [BW-1:0] f_bkt, b_bkt;

	// hold the configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_q  <= clt_pkg::RESET_EXPIRY;
			suspend_q <= clt_pkg::RESET_SUSPENSION;
			limit_q   <= clt_pkg::RESET_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				clt_pkg::REG_EXPIRY:  expiry_q  <= cfg_data;
				clt_pkg::REG_SUSPEND: suspend_q <= cfg_data;
				clt_pkg::REG_LIMIT:   limit_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	clt_front #(.BUCKETS(BUCKETS)) u_front (
		.clk, .arst_n,
		.req_valid(in_valid), .req_ready(in_ready), .req(in_data),
		.q_push(push), .q_full(full), .q_req(f_req), .q_bucket(f_bkt)
	);

	clt_queue #(.W(QW)) u_queue (
		.clk, .arst_n,
		.push(push), .wdata({f_req, f_bkt}), .full(full),
		.pop(pop), .nonempty(nonempty), .rdata({b_req, b_bkt})
	);

	clt_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
		.clk, .arst_n,
		.q_nonempty(nonempty), .q_req(b_req), .q_bucket(b_bkt), .q_pop(pop),
		.expiry_window(expiry_q), .suspension_time(suspend_q), .crash_limit(limit_q),
		.rsp_valid(out_valid), .rsp_ready(out_ready), .rsp(out_data)
	);
endmodule
